### rtl/phlp_pkg.sv
// Package with shared types and constants for the packet header length parser.
`timescale 1ns / 1ps

package phlp_pkg;

   // Ethernet types and IP protocol numbers recognized by the parser.
   localparam logic [15:0] TYPE_VLAN = 16'h8100;
   localparam logic [15:0] TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
   localparam logic [7:0]  PROTO_TCP = 8'd6;
   localparam logic [7:0]  PROTO_UDP = 8'd17;

   // Fixed header sizes in bytes, header field byte positions and the byte index limit.
   localparam logic [4:0] L2_PLAIN_BYTES  = 5'd14;
   localparam logic [4:0] L2_VLAN_BYTES   = 5'd18;
   localparam logic [5:0] IPV6_HDR_BYTES  = 6'd40;
   localparam logic [8:0] IPV4_MIN_BYTES  = 9'd20;
   localparam logic [8:0] TCP_MIN_BYTES   = 9'd20;
   localparam logic [8:0] UDP_HDR_BYTES   = 9'd8;
   localparam logic [7:0] IPV4_PROTO_POS  = 8'd9;
   localparam logic [7:0] IPV6_NEXT_POS   = 8'd6;
   localparam logic [7:0] TCP_OFFSET_POS  = 8'd12;
   localparam logic [7:0] TYPE_HI_POS     = 8'd12;
   localparam logic [7:0] TYPE_LO_POS     = 8'd13;
   localparam logic [7:0] INNER_HI_POS    = 8'd16;
   localparam logic [7:0] INNER_LO_POS    = 8'd17;
   localparam logic [7:0] BYTE_INDEX_MAX  = 8'd255;

   // Per-frame parse state.
   typedef struct packed {
      logic [7:0]  byte_index;
      logic [4:0]  l2_length;
      logic [15:0] ether_kind;
      logic [5:0]  l3_header_bytes;
      logic [7:0]  l4_protocol;
      logic [5:0]  tcp_header_bytes;
   } parse_state_type;

   localparam parse_state_type STATE_CLEAR = '{
      byte_index:       8'd0,
      l2_length:        L2_PLAIN_BYTES,
      ether_kind:       16'd0,
      l3_header_bytes:  6'd0,
      l4_protocol:      8'd0,
      tcp_header_bytes: 6'd0
   };

   // One parse result.
   typedef struct packed {
      logic [7:0] header_length;
      logic       tcp_found;
      logic [6:0] tcp_offset;
   } parse_result_type;

endpackage

### rtl/phlp_tracker.sv
// Frame byte tracker: holds the parse state and captures header fields by position.
`timescale 1ns / 1ps

module phlp_tracker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_advance,
   input  logic [7:0]               data_byte,
   input  logic                     last_byte,
   output phlp_pkg::parse_state_type state_next
);

   phlp_pkg::parse_state_type state_ff;
   phlp_pkg::parse_state_type state_in;

   logic [7:0] pos;
   logic [7:0] l2_wide;
   logic [7:0] tcp_pos;
   logic       is_ip;

   // Field capture for the current byte, based on its position in the frame.
   always_comb begin
      state_next = state_ff;
      pos        = state_ff.byte_index;

      if (pos == phlp_pkg::TYPE_HI_POS) begin
         state_next.ether_kind[15:8] = data_byte;
      end else if (pos == phlp_pkg::TYPE_LO_POS) begin
         state_next.ether_kind[7:0] = data_byte;
         if ({state_ff.ether_kind[15:8], data_byte} == phlp_pkg::TYPE_VLAN) begin
            state_next.l2_length = phlp_pkg::L2_VLAN_BYTES;
         end
      end else if (state_ff.l2_length == phlp_pkg::L2_VLAN_BYTES &&
                   pos == phlp_pkg::INNER_HI_POS) begin
         state_next.ether_kind[15:8] = data_byte;
      end else if (state_ff.l2_length == phlp_pkg::L2_VLAN_BYTES &&
                   pos == phlp_pkg::INNER_LO_POS) begin
         state_next.ether_kind[7:0] = data_byte;
      end

      is_ip   = (state_next.ether_kind == phlp_pkg::TYPE_IPV4) ||
                (state_next.ether_kind == phlp_pkg::TYPE_IPV6);
      l2_wide = {3'b000, state_next.l2_length};
      tcp_pos = l2_wide + {2'b00, state_ff.l3_header_bytes} + phlp_pkg::TCP_OFFSET_POS;

      if (is_ip && pos >= l2_wide) begin
         if (pos == l2_wide) begin
            if (state_next.ether_kind == phlp_pkg::TYPE_IPV4) begin
               state_next.l3_header_bytes = {data_byte[3:0], 2'b00};
            end else begin
               state_next.l3_header_bytes = phlp_pkg::IPV6_HDR_BYTES;
            end
         end else begin
            if (state_next.ether_kind == phlp_pkg::TYPE_IPV4 &&
                pos == l2_wide + phlp_pkg::IPV4_PROTO_POS) begin
               state_next.l4_protocol = data_byte;
            end
            if (state_next.ether_kind == phlp_pkg::TYPE_IPV6 &&
                pos == l2_wide + phlp_pkg::IPV6_NEXT_POS) begin
               state_next.l4_protocol = data_byte;
            end
            if (pos == tcp_pos) begin
               state_next.tcp_header_bytes = {data_byte[7:4], 2'b00};
            end
         end
      end

      // Saturating byte count.
      if (pos != phlp_pkg::BYTE_INDEX_MAX) begin
         state_next.byte_index = pos + 8'd1;
      end
   end

   // The state clears after the last byte of each frame.
   always_comb begin
      state_in = state_ff;
      if (byte_advance) begin
         state_in = last_byte ? phlp_pkg::STATE_CLEAR : state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= phlp_pkg::STATE_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/phlp_eval.sv
// Frame-end evaluation: checks lengths and types and forms the header length result.
`timescale 1ns / 1ps

module phlp_eval (
   input  phlp_pkg::parse_state_type  frame_state,
   output phlp_pkg::parse_result_type result
);

   logic [8:0] len;
   logic [8:0] l2;
   logic [8:0] l3_end;
   logic [8:0] total;
   logic       ok;
   logic       is_tcp;

   // All comparisons in 9 bits; the largest sum is well below 512.
   always_comb begin
      len    = {1'b0, frame_state.byte_index};
      l2     = {4'b0000, frame_state.l2_length};
      l3_end = l2 + {3'b000, frame_state.l3_header_bytes};
      total  = l3_end;
      ok     = 1'b1;
      is_tcp = 1'b0;

      if (len < 9'(phlp_pkg::L2_PLAIN_BYTES)) begin
         ok = 1'b0;
      end
      if (frame_state.l2_length == phlp_pkg::L2_VLAN_BYTES &&
          len < 9'(phlp_pkg::L2_VLAN_BYTES)) begin
         ok = 1'b0;
      end

      // Network layer type and minimum length.
      if (frame_state.ether_kind == phlp_pkg::TYPE_IPV4) begin
         if (len < l2 + phlp_pkg::IPV4_MIN_BYTES) begin
            ok = 1'b0;
         end
      end else if (frame_state.ether_kind == phlp_pkg::TYPE_IPV6) begin
         if (len < l2 + 9'(phlp_pkg::IPV6_HDR_BYTES)) begin
            ok = 1'b0;
         end
      end else begin
         ok = 1'b0;
      end

      // Transport layer header.
      if (frame_state.l4_protocol == phlp_pkg::PROTO_TCP) begin
         is_tcp = 1'b1;
         if (len < l3_end + phlp_pkg::TCP_MIN_BYTES) begin
            ok = 1'b0;
         end
         total = l3_end + {3'b000, frame_state.tcp_header_bytes};
      end else if (frame_state.l4_protocol == phlp_pkg::PROTO_UDP) begin
         total = l3_end + phlp_pkg::UDP_HDR_BYTES;
      end else begin
         ok = 1'b0;
      end

      if (len < total) begin
         ok = 1'b0;
      end

      result.header_length = ok ? total[7:0] : 8'd0;
      result.tcp_found     = ok && is_tcp;
      result.tcp_offset    = (ok && is_tcp) ? l3_end[6:0] : 7'd0;
   end

endmodule

### rtl/packet_header_length_parser_unit.sv
// Top level of the packet header length parser: input register, tracker, evaluation, result register.
`timescale 1ns / 1ps

// Takes one frame byte per transfer and gives one result transfer after the
// byte marked last: the header length through the TCP or UDP header (0 on a
// failed parse), a TCP flag and the TCP header offset. Each byte passes an
// input register and then the tracker's field capture; when the last byte
// moves on, the length checks load the result register. The block takes a
// byte in every cycle unless a last byte waits on a stalled result register.
// While a result waits on a stalled output, bytes of the next frame keep
// flowing until that frame's last byte reaches the input register.
module packet_header_length_parser_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_header_length,
   output logic       rsp_tcp_found,
   output logic [6:0] rsp_tcp_offset
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_data_ff;
   logic [7:0] in_data_in;
   logic       in_last_ff;
   logic       in_last_in;

   logic       out_valid_ff;
   logic       out_valid_in;
   phlp_pkg::parse_result_type out_result_ff;
   phlp_pkg::parse_result_type out_result_in;

   phlp_pkg::parse_state_type  frame_state;
   phlp_pkg::parse_result_type eval_result;

   logic out_free;
   logic byte_advance;
   logic req_transfer;

   // A registered byte moves on unless it ends a frame and the result slot is full and stalled.
   assign out_free     = !out_valid_ff || !rsp_stall;
   assign byte_advance = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall    = in_valid_ff && !byte_advance;
   assign req_transfer = req_valid && !req_stall;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_last_in  = in_last_ff;
      if (req_transfer) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data_byte;
         in_last_in  = req_last_byte;
      end else if (byte_advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_data_ff <= in_data_in;
      in_last_ff <= in_last_in;
   end

   phlp_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .byte_advance (byte_advance),
      .data_byte    (in_data_ff),
      .last_byte    (in_last_ff),
      .state_next   (frame_state)
   );

   phlp_eval u_eval (
      .frame_state (frame_state),
      .result      (eval_result)
   );

   // Result register, loaded when the last byte of a frame moves on.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      if (byte_advance && in_last_ff) begin
         out_valid_in  = 1'b1;
         out_result_in = eval_result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_result_ff <= out_result_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_header_length = out_result_ff.header_length;
   assign rsp_tcp_found     = out_result_ff.tcp_found;
   assign rsp_tcp_offset    = out_result_ff.tcp_offset;

endmodule
